### rtl/qfe_pkg.sv
package qfe_pkg;

  // default counter width
  localparam int LenBitsDefault = 16;

  // queue between front and back
  localparam int QueueDepth = 2;

  // register reset values
  localparam logic [63:0] TermMap0Rst = 64'h7C00_1077_0000_0200;
  localparam logic [63:0] TermMapRst  = 64'h0;
  localparam logic [15:0] MaxLenRst   = 16'd255;

  // character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_LC_N  = 8'h6E;
  localparam logic [7:0] CH_LC_R  = 8'h72;
  localparam logic [7:0] CH_LC_E  = 8'h65;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;

  // register map (index = byte address / 8)
  typedef enum logic [2:0] {
    REG_TERM_MAP_0 = 3'd0,
    REG_TERM_MAP_1 = 3'd1,
    REG_TERM_MAP_2 = 3'd2,
    REG_TERM_MAP_3 = 3'd3,
    REG_MAX_LEN    = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_SKIP = 2'd0,
    PH_BODY = 2'd1,
    PH_ESC  = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    Q_NONE   = 2'd0,
    Q_SINGLE = 2'd1,
    Q_DOUBLE = 2'd2
  } quote_t;

  // one classified input word
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] esc_data;
    logic       last;
    logic       blank;
    logic       sq;
    logic       dq;
    logic       bsl;
    logic       term;
  } item_t;

endpackage

### rtl/qfe_front.sv
module qfe_front (
  input  logic             in_valid,
  input  logic [7:0]       in_byte,
  input  logic             last_byte,
  output logic             in_stall,
  input  logic [63:0]      term_map_0,
  input  logic [63:0]      term_map_1,
  input  logic [63:0]      term_map_2,
  input  logic [63:0]      term_map_3,
  input  logic             q_full,
  output logic             push,
  output qfe_pkg::item_t   push_item
);

  logic [63:0] map_word;

  // stall only when the queue has no room
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // pick the terminator word by the top two bits
  always_comb begin
    case (in_byte[7:6])
      2'd0:    map_word = term_map_0;
      2'd1:    map_word = term_map_1;
      2'd2:    map_word = term_map_2;
      default: map_word = term_map_3;
    endcase
  end

  // classify the byte
  always_comb begin
    push_item.data  = in_byte;
    push_item.last  = last_byte;
    push_item.blank = (in_byte == qfe_pkg::CH_SPACE) || (in_byte == qfe_pkg::CH_TAB);
    push_item.sq    = (in_byte == qfe_pkg::CH_SQ);
    push_item.dq    = (in_byte == qfe_pkg::CH_DQ);
    push_item.bsl   = (in_byte == qfe_pkg::CH_BSL);
    push_item.term  = map_word[in_byte[5:0]];
    case (in_byte)
      qfe_pkg::CH_LC_N: push_item.esc_data = qfe_pkg::CH_NL;
      qfe_pkg::CH_LC_R: push_item.esc_data = qfe_pkg::CH_CR;
      qfe_pkg::CH_LC_E: push_item.esc_data = qfe_pkg::CH_ESC;
      default:          push_item.esc_data = in_byte;
    endcase
  end

endmodule

### rtl/qfe_queue.sv
module qfe_queue #(
  parameter int DEPTH = qfe_pkg::QueueDepth
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  qfe_pkg::item_t   push_item,
  input  logic             pop,
  output logic             not_empty,
  output logic             full,
  output qfe_pkg::item_t   head
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  qfe_pkg::item_t mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;

  assign not_empty = (fill != '0);
  assign full      = (fill == CntW'(DEPTH));
  assign head      = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### rtl/qfe_back.sv
module qfe_back #(
  parameter int LEN_BITS = qfe_pkg::LenBitsDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [15:0]      max_len,
  input  logic             q_not_empty,
  input  qfe_pkg::item_t   item,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_char,
  output logic             char_valid,
  output logic             field_end,
  output logic [15:0]      field_length
);

  localparam int CmpW = (LEN_BITS > 16) ? LEN_BITS : 16;

  qfe_pkg::phase_t phase, phase_next;
  qfe_pkg::quote_t quote, quote_next;
  logic [LEN_BITS-1:0] count, count_next, count_inc;
  logic [CmpW-1:0] limit_w;

  logic ready;
  logic at_limit;
  logic inc_limit;
  logic skip_hold;
  logic body_end;
  qfe_pkg::quote_t q_eff;

  logic        res_valid;
  logic        res_cv;
  logic        res_fe;
  logic [7:0]  res_char;
  logic [15:0] res_len;

  // output register free or being drained
  assign ready = !out_valid || !out_stall;
  assign pop   = q_not_empty && ready;

  // limit compares; an all-ones count is the saturated limit
  assign limit_w   = CmpW'(max_len);
  assign count_inc = count + 1'b1;
  assign at_limit  = (CmpW'(count) >= limit_w) || (&count);
  assign inc_limit = (CmpW'(count_inc) >= limit_w) || (&count_inc);

  // decode of the head word
  assign skip_hold = (phase == qfe_pkg::PH_SKIP) && (item.blank || item.sq || item.dq);
  assign q_eff     = (phase == qfe_pkg::PH_SKIP) ? qfe_pkg::Q_NONE : quote;
  assign body_end  = at_limit
                  || ((q_eff == qfe_pkg::Q_NONE) && item.term)
                  || ((q_eff == qfe_pkg::Q_DOUBLE) && item.dq)
                  || ((q_eff == qfe_pkg::Q_SINGLE) && item.sq);

  // next state
  always_comb begin
    phase_next = phase;
    quote_next = quote;
    count_next = count;
    if (pop) begin
      unique case (phase) inside
        qfe_pkg::PH_DONE: begin
          if (item.last) begin
            phase_next = qfe_pkg::PH_SKIP;
          end
        end
        qfe_pkg::PH_ESC: begin
          if (item.last || inc_limit) begin
            phase_next = item.last ? qfe_pkg::PH_SKIP : qfe_pkg::PH_DONE;
            quote_next = qfe_pkg::Q_NONE;
            count_next = '0;
          end else begin
            phase_next = qfe_pkg::PH_BODY;
            count_next = count_inc;
          end
        end
        qfe_pkg::PH_SKIP, qfe_pkg::PH_BODY: begin
          if (skip_hold) begin
            if (item.last) begin
              phase_next = qfe_pkg::PH_SKIP;
              quote_next = qfe_pkg::Q_NONE;
              count_next = '0;
            end else if (item.sq) begin
              phase_next = qfe_pkg::PH_BODY;
              quote_next = qfe_pkg::Q_SINGLE;
            end else if (item.dq) begin
              phase_next = qfe_pkg::PH_BODY;
              quote_next = qfe_pkg::Q_DOUBLE;
            end
          end else if (body_end || (item.bsl && item.last)) begin
            phase_next = item.last ? qfe_pkg::PH_SKIP : qfe_pkg::PH_DONE;
            quote_next = qfe_pkg::Q_NONE;
            count_next = '0;
          end else if (item.bsl) begin
            phase_next = qfe_pkg::PH_ESC;
            quote_next = q_eff;
          end else if (item.last || inc_limit) begin
            phase_next = item.last ? qfe_pkg::PH_SKIP : qfe_pkg::PH_DONE;
            quote_next = qfe_pkg::Q_NONE;
            count_next = '0;
          end else begin
            phase_next = qfe_pkg::PH_BODY;
            quote_next = q_eff;
            count_next = count_inc;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  // result of the head word
  always_comb begin
    res_valid = 1'b0;
    res_cv    = 1'b0;
    res_fe    = 1'b0;
    res_char  = '0;
    res_len   = '0;
    unique case (phase) inside
      qfe_pkg::PH_DONE: begin
        res_valid = 1'b0;
      end
      qfe_pkg::PH_ESC: begin
        res_valid = 1'b1;
        res_cv    = 1'b1;
        res_char  = item.esc_data;
        res_fe    = item.last || inc_limit;
        res_len   = res_fe ? 16'(count_inc) : '0;
      end
      qfe_pkg::PH_SKIP, qfe_pkg::PH_BODY: begin
        if (skip_hold) begin
          // blank buffer or opening quote on the last byte
          res_valid = item.last;
          res_fe    = item.last;
        end else if (body_end || (item.bsl && item.last)) begin
          res_valid = 1'b1;
          res_fe    = 1'b1;
          res_len   = 16'(count);
        end else if (!item.bsl) begin
          res_valid = 1'b1;
          res_cv    = 1'b1;
          res_char  = item.data;
          res_fe    = item.last || inc_limit;
          res_len   = res_fe ? 16'(count_inc) : '0;
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // field state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= qfe_pkg::PH_SKIP;
      quote <= qfe_pkg::Q_NONE;
      count <= '0;
    end else begin
      phase <= phase_next;
      quote <= quote_next;
      count <= count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= pop && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      out_char     <= res_char;
      char_valid   <= res_cv;
      field_end    <= res_fe;
      field_length <= res_len;
    end
  end

endmodule

### rtl/quoted_field_extractor.sv
// Quoted field extractor: takes one source byte per word (last_byte marks the
// buffer's end), skips leading blanks, handles an optional quote and backslash
// escapes, and gives one result word per copied byte plus the end-of-field
// length. Sustained rate is one byte per clock while out_stall is low; the
// back-end state machine retires one queued byte per cycle. A byte's result
// reaches the output through the two-word queue and then the output register,
// into which the back end decodes it. in_stall rises only when the queue is
// full, which happens when out_stall has held results back. Registers sit at
// byte address 8*i on the 64-bit APB port and may be written only while the
// block is idle.
module quoted_field_extractor #(
  parameter int LEN_BITS = qfe_pkg::LenBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        last_byte,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        char_valid,
  output logic        field_end,
  output logic [15:0] field_length,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [63:0] term_map_0;
  logic [63:0] term_map_1;
  logic [63:0] term_map_2;
  logic [63:0] term_map_3;
  logic [15:0] max_len;

  logic           wr_en;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_not_empty;
  qfe_pkg::item_t push_item;
  qfe_pkg::item_t head_item;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      term_map_0 <= qfe_pkg::TermMap0Rst;
      term_map_1 <= qfe_pkg::TermMapRst;
      term_map_2 <= qfe_pkg::TermMapRst;
      term_map_3 <= qfe_pkg::TermMapRst;
      max_len    <= qfe_pkg::MaxLenRst;
    end else if (wr_en) begin
      unique case (paddr[5:3])
        qfe_pkg::REG_TERM_MAP_0: term_map_0 <= pwdata;
        qfe_pkg::REG_TERM_MAP_1: term_map_1 <= pwdata;
        qfe_pkg::REG_TERM_MAP_2: term_map_2 <= pwdata;
        qfe_pkg::REG_TERM_MAP_3: term_map_3 <= pwdata;
        qfe_pkg::REG_MAX_LEN:    max_len    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (paddr[5:3])
      qfe_pkg::REG_TERM_MAP_0: prdata = term_map_0;
      qfe_pkg::REG_TERM_MAP_1: prdata = term_map_1;
      qfe_pkg::REG_TERM_MAP_2: prdata = term_map_2;
      qfe_pkg::REG_TERM_MAP_3: prdata = term_map_3;
      qfe_pkg::REG_MAX_LEN:    prdata = {48'd0, max_len};
      default:                 prdata = '0;
    endcase
  end

  qfe_front u_front (
    .in_valid   (in_valid),
    .in_byte    (in_byte),
    .last_byte  (last_byte),
    .in_stall   (in_stall),
    .term_map_0 (term_map_0),
    .term_map_1 (term_map_1),
    .term_map_2 (term_map_2),
    .term_map_3 (term_map_3),
    .q_full     (q_full),
    .push       (push),
    .push_item  (push_item)
  );

  qfe_queue #(
    .DEPTH (qfe_pkg::QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .not_empty (q_not_empty),
    .full      (q_full),
    .head      (head_item)
  );

  qfe_back #(
    .LEN_BITS (LEN_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .max_len      (max_len),
    .q_not_empty  (q_not_empty),
    .item         (head_item),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .char_valid   (char_valid),
    .field_end    (field_end),
    .field_length (field_length)
  );

endmodule

### rtl/qfe_checker.sv
module qfe_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_char,
  input logic        char_valid,
  input logic        field_end,
  input logic [15:0] field_length,
  input logic        pready
);

  // every result word carries a byte or an end of field
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (char_valid || field_end))
    else $error("result word with neither byte nor field end");

  // no stray character data
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !char_valid) |-> (out_char == 8'd0))
    else $error("out_char nonzero without char_valid");

  // length only shown at field end
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !field_end) |-> (field_length == 16'd0))
    else $error("field_length nonzero before field end");

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_char) && $stable(char_valid)
       && $stable(field_end) && $stable(field_length)))
    else $error("stalled result changed");

  // the register port never waits
  assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind quoted_field_extractor qfe_checker u_qfe_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_char     (out_char),
  .char_valid   (char_valid),
  .field_end    (field_end),
  .field_length (field_length),
  .pready       (pready)
);
